@@ rtl/gps_compass_serial_frame_decoder_unit_assert.svh @@
// Assertion macros used by the frame decoder RTL.
`ifndef GPS_COMPASS_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH
`define GPS_COMPASS_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GCSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame decoder assertion failed");

`endif

@@ rtl/gcsfd_pkg.sv @@
// Package with the frame constants and result type of the frame decoder.
`default_nettype none

package gcsfd_pkg;

	// Frame framing bytes and the accepted id/length pairs.
	localparam logic [7:0] SYNC_1      = 8'h55;
	localparam logic [7:0] SYNC_2      = 8'hAA;
	localparam logic [7:0] ID_GPS      = 8'h10;
	localparam logic [7:0] ID_COMPASS  = 8'h20;
	localparam logic [7:0] LEN_GPS     = 8'h3A;
	localparam logic [7:0] LEN_COMPASS = 8'h06;

	// Only the first bytes of a payload carry fields that are decoded.
	localparam int CAP_BYTES = 56;

	// Payload byte offsets of the decoded fields.
	localparam int OFS_TIME   = 0;
	localparam int OFS_LON    = 4;
	localparam int OFS_LAT    = 8;
	localparam int OFS_ALT    = 12;
	localparam int OFS_NVEL   = 28;
	localparam int OFS_EVEL   = 32;
	localparam int OFS_DVEL   = 36;
	localparam int OFS_VDOP   = 42;
	localparam int OFS_NDOP   = 44;
	localparam int OFS_EDOP   = 46;
	localparam int OFS_SATS   = 48;
	localparam int OFS_FTYPE  = 50;
	localparam int OFS_FFLAG  = 52;
	localparam int OFS_MASK   = 55;
	localparam int OFS_MAG_X  = 0;
	localparam int OFS_MAG_Y  = 2;
	localparam int OFS_MAGKEY = 4;

	// Fix decoding.
	localparam logic [7:0] FIX_TYPE_2D = 8'h02;
	localparam logic [7:0] FIX_TYPE_3D = 8'h03;
	localparam logic [7:0] FLAG_DIFF   = 8'h02;

	localparam logic [1:0] FIX_NONE = 2'd0;
	localparam logic [1:0] FIX_2D   = 2'd1;
	localparam logic [1:0] FIX_3D   = 2'd2;
	localparam logic [1:0] FIX_DIFF = 2'd3;

	localparam logic KIND_GPS     = 1'b0;
	localparam logic KIND_COMPASS = 1'b1;

	// One decoded result.
	typedef struct packed {
		logic               frame_kind;
		logic [31:0]        time_word;
		logic [5:0]         corrected_day;
		logic signed [31:0] lon_or_mag_x;
		logic signed [31:0] lat_or_mag_y;
		logic signed [31:0] altitude_mm;
		logic signed [31:0] north_velocity;
		logic signed [31:0] east_velocity;
		logic signed [31:0] climb_rate;
		logic [47:0]        dop_triple;
		logic [7:0]         satellites;
		logic [1:0]         fix_class;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/gcsfd_byte_if.sv @@
// Valid/ready channel that carries one received serial byte per beat.
`default_nettype none

interface gcsfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/gcsfd_result_if.sv @@
// Valid/ready channel that carries one decoded frame result per beat.
`default_nettype none

interface gcsfd_result_if;
	logic               valid;
	logic               ready;
	logic               frame_kind;
	logic [31:0]        time_word;
	logic [5:0]         corrected_day;
	logic signed [31:0] lon_or_mag_x;
	logic signed [31:0] lat_or_mag_y;
	logic signed [31:0] altitude_mm;
	logic signed [31:0] north_velocity;
	logic signed [31:0] east_velocity;
	logic signed [31:0] climb_rate;
	logic [47:0]        dop_triple;
	logic [7:0]         satellites;
	logic [1:0]         fix_class;

	modport source (
		output valid, frame_kind, time_word, corrected_day, lon_or_mag_x, lat_or_mag_y,
		output altitude_mm, north_velocity, east_velocity, climb_rate, dop_triple,
		output satellites, fix_class,
		input ready
	);
	modport sink (
		input valid, frame_kind, time_word, corrected_day, lon_or_mag_x, lat_or_mag_y,
		input altitude_mm, north_velocity, east_velocity, climb_rate, dop_triple,
		input satellites, fix_class,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/gps_compass_serial_frame_decoder_unit.sv @@
// Serial frame decoder: one received byte per beat in, one decoded frame result out.
//
// The rx channel takes one serial byte per beat. The decoder hunts for the 55 AA
// header, checks the id/length pair, collects the payload and verifies the two
// running-sum checksum bytes. Any byte that does not fit sends it back to hunting.
// A frame that passes gives one beat on the res channel: a gps frame carries the
// unmasked time, position, velocity, dop and fix fields, a compass frame carries
// x and y centred on the running min/max of all compass readings seen so far.
// Throughput is one byte per cycle while rx.ready is high. A byte is registered on
// entry and decoded from that input register; a frame's result is written once its
// last checksum byte is decoded. The result sits in an output register, so bytes keep
// flowing while it waits; only when that register is still full and res.ready is
// low does rx.ready drop, and it rises again as soon as the result is taken.
// Reset returns the decoder to hunting, clears both checksums and the compass
// min/max store, and empties the input and output registers.
`default_nettype none
`include "gps_compass_serial_frame_decoder_unit_assert.svh"

module gps_compass_serial_frame_decoder_unit
	import gcsfd_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	gcsfd_byte_if.sink     rx,
	gcsfd_result_if.source res
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_ID,
		PH_LEN,
		PH_PAYLOAD,
		PH_CHK_A,
		PH_CHK_B
	} phase_t;

	// Input register.
	logic       v_s1;
	logic [7:0] b_s1;

	// Frame state.
	phase_t      phase_q, phase_nx;
	logic        id_gps_q, id_cmp_q;
	logic [5:0]  len_q;
	logic [5:0]  cnt_q;
	logic [7:0]  sa_q, sb_q;
	logic [7:0]  pl_q [CAP_BYTES];
	logic signed [15:0] xmax_q, xmin_q, ymax_q, ymin_q;

	// Output register.
	logic res_valid_q;
	res_t res_q;

	logic       adv;
	logic       done;
	logic       clr_sums;
	logic       add_sum;
	logic [7:0] sa_add, sb_add;
	logic [5:0] cnt_inc;

	// The decode stage moves whenever it holds a byte and the output register can take a result.
	assign adv      = v_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !v_s1 || !res_valid_q || res.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			b_s1 <= rx.rx_byte;
		end
	end

	// Running checksums over id, length and payload.
	assign sa_add  = sa_q + b_s1;
	assign sb_add  = sb_q + sa_add;
	assign cnt_inc = cnt_q + 6'd1;

	// Next phase for the byte in the decode stage.
	always_comb begin
		phase_nx = PH_HUNT;
		done     = 1'b0;
		clr_sums = 1'b0;
		add_sum  = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (b_s1 == SYNC_1) phase_nx = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (b_s1 == SYNC_2) begin
					phase_nx = PH_ID;
					clr_sums = 1'b1;
				end
			end
			PH_ID: begin
				phase_nx = PH_LEN;
				add_sum  = 1'b1;
			end
			PH_LEN: begin
				if ((id_gps_q && b_s1 == LEN_GPS) || (id_cmp_q && b_s1 == LEN_COMPASS)) begin
					phase_nx = PH_PAYLOAD;
					add_sum  = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				add_sum  = 1'b1;
				phase_nx = (cnt_inc >= len_q) ? PH_CHK_A : PH_PAYLOAD;
			end
			PH_CHK_A: begin
				if (b_s1 == sa_q) phase_nx = PH_CHK_B;
			end
			PH_CHK_B: begin
				if (b_s1 == sb_q) done = 1'b1;
			end
			default: begin
				phase_nx = PH_HUNT;
			end
		endcase
	end

	// Payload capture; only the first CAP_BYTES bytes, which hold all decoded fields, are kept.
	always_ff @(posedge clk) begin
		if (adv && phase_q == PH_PAYLOAD && cnt_q < 6'(CAP_BYTES)) begin
			pl_q[cnt_q] <= b_s1;
		end
	end

	function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] m);
		get32 = {b3 ^ m, b2 ^ m, b1 ^ m, b0 ^ m};
	endfunction

	function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] m);
		get16 = {b1 ^ m, b0 ^ m};
	endfunction

	// Gps field decode.
	logic [7:0]  gm;
	logic [31:0] g_time, g_down;
	logic [7:0]  g_ftype, g_fflag;
	logic [1:0]  g_fix;

	assign gm      = pl_q[OFS_MASK];
	assign g_time  = get32(pl_q[OFS_TIME], pl_q[OFS_TIME+1], pl_q[OFS_TIME+2],
		pl_q[OFS_TIME+3], gm);
	assign g_down  = get32(pl_q[OFS_DVEL], pl_q[OFS_DVEL+1], pl_q[OFS_DVEL+2],
		pl_q[OFS_DVEL+3], gm);
	assign g_ftype = pl_q[OFS_FTYPE] ^ gm;
	assign g_fflag = pl_q[OFS_FFLAG] ^ gm;

	always_comb begin
		if (g_ftype == FIX_TYPE_2D) begin
			g_fix = FIX_2D;
		end else if (g_ftype == FIX_TYPE_3D) begin
			g_fix = FIX_3D;
		end else begin
			g_fix = FIX_NONE;
		end
		if (g_fix != FIX_NONE && (g_fflag & FLAG_DIFF) != 8'h00) begin
			g_fix = FIX_DIFF;
		end
	end

	// Compass decode: key byte mask, extremes update and centring.
	logic [7:0]         ck, cm;
	logic signed [15:0] cx, cy;
	logic signed [15:0] xmax_nx, xmin_nx, ymax_nx, ymin_nx;
	logic signed [16:0] xsum, ysum, xsum_r, ysum_r;
	logic signed [15:0] xmid, ymid;
	logic signed [31:0] cx_c, cy_c;

	assign ck = pl_q[OFS_MAGKEY];
	assign cm = {ck[4:1], ck[3:0] ^ ck[7:4]} ^ {ck[0], 3'b000, ck[0], 3'b000};
	assign cx = get16(pl_q[OFS_MAG_X], pl_q[OFS_MAG_X+1], cm);
	assign cy = get16(pl_q[OFS_MAG_Y], pl_q[OFS_MAG_Y+1], cm);

	assign xmax_nx = (cx > xmax_q) ? cx : xmax_q;
	assign xmin_nx = (cx < xmin_q) ? cx : xmin_q;
	assign ymax_nx = (cy > ymax_q) ? cy : ymax_q;
	assign ymin_nx = (cy < ymin_q) ? cy : ymin_q;

	// Halving rounds toward zero: add one to a negative sum before the shift.
	assign xsum   = 17'(xmax_nx) + 17'(xmin_nx);
	assign ysum   = 17'(ymax_nx) + 17'(ymin_nx);
	assign xsum_r = xsum + {16'd0, xsum[16]};
	assign ysum_r = ysum + {16'd0, ysum[16]};
	assign xmid   = xsum_r[16:1];
	assign ymid   = ysum_r[16:1];
	assign cx_c   = 32'(cx) - 32'(xmid);
	assign cy_c   = 32'(cy) - 32'(ymid);

	// Result assembly.
	res_t res_nx;

	always_comb begin
		res_nx = '0;
		if (id_gps_q) begin
			res_nx.frame_kind     = KIND_GPS;
			res_nx.time_word      = g_time;
			res_nx.corrected_day  = {1'b0, g_time[20:16]} + {5'd0, (g_time[15:12] > 4'd7)};
			res_nx.lon_or_mag_x   = get32(pl_q[OFS_LON], pl_q[OFS_LON+1], pl_q[OFS_LON+2],
				pl_q[OFS_LON+3], gm);
			res_nx.lat_or_mag_y   = get32(pl_q[OFS_LAT], pl_q[OFS_LAT+1], pl_q[OFS_LAT+2],
				pl_q[OFS_LAT+3], gm);
			res_nx.altitude_mm    = get32(pl_q[OFS_ALT], pl_q[OFS_ALT+1], pl_q[OFS_ALT+2],
				pl_q[OFS_ALT+3], gm);
			res_nx.north_velocity = get32(pl_q[OFS_NVEL], pl_q[OFS_NVEL+1], pl_q[OFS_NVEL+2],
				pl_q[OFS_NVEL+3], gm);
			res_nx.east_velocity  = get32(pl_q[OFS_EVEL], pl_q[OFS_EVEL+1], pl_q[OFS_EVEL+2],
				pl_q[OFS_EVEL+3], gm);
			res_nx.climb_rate     = (g_down == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - g_down);
			res_nx.dop_triple     = {get16(pl_q[OFS_VDOP], pl_q[OFS_VDOP+1], gm),
				get16(pl_q[OFS_NDOP], pl_q[OFS_NDOP+1], gm),
				get16(pl_q[OFS_EDOP], pl_q[OFS_EDOP+1], gm)};
			res_nx.satellites     = pl_q[OFS_SATS];
			res_nx.fix_class      = g_fix;
		end else begin
			res_nx.frame_kind   = KIND_COMPASS;
			res_nx.lon_or_mag_x = cx_c;
			res_nx.lat_or_mag_y = cy_c;
		end
	end

	// Frame state, compass extremes and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			id_gps_q    <= 1'b0;
			id_cmp_q    <= 1'b0;
			len_q       <= '0;
			cnt_q       <= '0;
			sa_q        <= '0;
			sb_q        <= '0;
			xmax_q      <= '0;
			xmin_q      <= '0;
			ymax_q      <= '0;
			ymin_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (adv) begin
				phase_q <= phase_nx;
				if (clr_sums) begin
					sa_q <= '0;
					sb_q <= '0;
				end else if (add_sum) begin
					sa_q <= sa_add;
					sb_q <= sb_add;
				end
				if (phase_q == PH_ID) begin
					id_gps_q <= (b_s1 == ID_GPS);
					id_cmp_q <= (b_s1 == ID_COMPASS);
				end
				if (phase_q == PH_LEN) begin
					len_q <= b_s1[5:0];
					cnt_q <= '0;
				end
				if (phase_q == PH_PAYLOAD) begin
					cnt_q <= cnt_inc;
				end
				if (done) begin
					res_valid_q <= 1'b1;
					res_q       <= res_nx;
					if (!id_gps_q) begin
						xmax_q <= xmax_nx;
						xmin_q <= xmin_nx;
						ymax_q <= ymax_nx;
						ymin_q <= ymin_nx;
					end
				end
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.frame_kind     = res_q.frame_kind;
	assign res.time_word      = res_q.time_word;
	assign res.corrected_day  = res_q.corrected_day;
	assign res.lon_or_mag_x   = res_q.lon_or_mag_x;
	assign res.lat_or_mag_y   = res_q.lat_or_mag_y;
	assign res.altitude_mm    = res_q.altitude_mm;
	assign res.north_velocity = res_q.north_velocity;
	assign res.east_velocity  = res_q.east_velocity;
	assign res.climb_rate     = res_q.climb_rate;
	assign res.dop_triple     = res_q.dop_triple;
	assign res.satellites     = res_q.satellites;
	assign res.fix_class      = res_q.fix_class;

	// A new result only follows a byte decoded in the second checksum phase.
	`GCSFD_ASSERT_IMPL(a_res_after_chk, clk, arst_n, $rose(res_valid_q), $past(phase_q) == PH_CHK_B)
	// After a frame completes the decoder is hunting again.
	`GCSFD_ASSERT_NEXT(a_hunt_after_done, clk, arst_n, adv && done, phase_q == PH_HUNT)
	// The payload count stays below the frame length while collecting.
	`GCSFD_ASSERT_IMPL(a_cnt_in_frame, clk, arst_n, phase_q == PH_PAYLOAD, cnt_q < len_q)
	// The stored extremes never cross.
	`GCSFD_ASSERT_IMPL(a_x_extremes, clk, arst_n, 1'b1, xmax_q >= xmin_q)
	`GCSFD_ASSERT_IMPL(a_y_extremes, clk, arst_n, 1'b1, ymax_q >= ymin_q)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the serial GPS/compass frame decoder.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gcsfd_pkg::*;

	// Header bytes ahead of the payload, and where id and length sit in a frame.
	localparam int HDR_BYTES = 4;
	localparam int POS_SYNC_2 = 1;
	localparam int POS_ID = 2;
	localparam int POS_LEN = 3;
	localparam int FRAME_MAX = HDR_BYTES + int'(LEN_GPS) + 2;
	localparam int BODY_MAX = int'(LEN_GPS);

	// Size of the random part, and the run-time limits.
	localparam int RANDOM_BYTES = 400;
	localparam int RANDOM_RESULTS = 48;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	// Where the decoder stands in a frame.
	typedef enum logic [2:0] {
		PH_HUNT, PH_SYNC, PH_ID, PH_LEN, PH_BODY, PH_SUM_A, PH_SUM_B
	} frame_state_e;

	logic clk;
	logic arst_n;

	gcsfd_byte_if rx_ch();
	gcsfd_result_if res_ch();

	gps_compass_serial_frame_decoder_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch)
	);

	// Decoder state as the testbench tracks it.
	frame_state_e hunt_phase = PH_HUNT;
	logic [7:0] cur_id = 8'h00;
	logic [5:0] cur_len = 6'd0;
	logic [6:0] body_cnt = 7'd0;
	logic [7:0] sum_a = 8'h00;
	logic [7:0] sum_b = 8'h00;
	logic [7:0] body_mem [64];
	logic signed [15:0] x_hi = '0;
	logic signed [15:0] x_lo = '0;
	logic signed [15:0] y_hi = '0;
	logic signed [15:0] y_lo = '0;

	res_t decoded_frames [$];
	res_t head_frame;
	logic [7:0] body_buf [BODY_MAX];

	int fault_count = 0;
	int results_seen = 0;
	int frame_bytes = 0;
	int burst_left = 0;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mask byte of a compass frame, derived from its key byte.
	function automatic logic [7:0] compass_key(input logic [7:0] seed);
		logic [7:0] k;
		k = ((seed ^ (seed >> 4)) & 8'h0F) | ((seed << 3) & 8'hF0);
		return k ^ {seed[0], 3'b000, seed[0], 3'b000};
	endfunction

	function automatic logic [31:0] body_le32(input int ofs, input logic [7:0] key);
		return {body_mem[ofs + 3] ^ key, body_mem[ofs + 2] ^ key,
			body_mem[ofs + 1] ^ key, body_mem[ofs] ^ key};
	endfunction

	function automatic logic [15:0] body_le16(input int ofs, input logic [7:0] key);
		return {body_mem[ofs + 1] ^ key, body_mem[ofs] ^ key};
	endfunction

	task automatic add_to_sums(input logic [7:0] b);
		sum_a = sum_a + b;
		sum_b = sum_b + sum_a;
	endtask

	// Runs one accepted byte through the frame decoder and queues any result.
	task automatic decode_byte(input logic [7:0] b);
		res_t r;
		logic [7:0] key;
		logic [7:0] ft;
		logic [7:0] ff;
		logic [31:0] tw;
		logic [31:0] down;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic done;
		done = 1'b0;
		if (hunt_phase == PH_HUNT && b == SYNC_1) begin
			hunt_phase = PH_SYNC;
		end else if (hunt_phase == PH_SYNC && b == SYNC_2) begin
			sum_a = 8'h00;
			sum_b = 8'h00;
			hunt_phase = PH_ID;
		end else if (hunt_phase == PH_ID) begin
			cur_id = b;
			add_to_sums(b);
			hunt_phase = PH_LEN;
		end else if (hunt_phase == PH_LEN && ((cur_id == ID_GPS && b == LEN_GPS) ||
				(cur_id == ID_COMPASS && b == LEN_COMPASS))) begin
			cur_len = b[5:0];
			body_cnt = 7'd0;
			add_to_sums(b);
			hunt_phase = PH_BODY;
		end else if (hunt_phase == PH_BODY) begin
			body_mem[body_cnt[5:0]] = b;
			body_cnt = body_cnt + 7'd1;
			add_to_sums(b);
			if (body_cnt >= {1'b0, cur_len})
				hunt_phase = PH_SUM_A;
		end else if (hunt_phase == PH_SUM_A && b == sum_a) begin
			hunt_phase = PH_SUM_B;
		end else if (hunt_phase == PH_SUM_B && b == sum_b) begin
			done = 1'b1;
			hunt_phase = PH_HUNT;
		end else begin
			hunt_phase = PH_HUNT;
		end

		if (done) begin
			r = '0;
			if (cur_id == ID_GPS) begin
				key = body_mem[OFS_MASK];
				tw = body_le32(OFS_TIME, key);
				down = body_le32(OFS_DVEL, key);
				ft = body_mem[OFS_FTYPE] ^ key;
				ff = body_mem[OFS_FFLAG] ^ key;
				r.frame_kind = KIND_GPS;
				r.time_word = tw;
				// Day moves on when the hour field is past 7.
				r.corrected_day = {1'b0, tw[20:16]} + ((tw[15:12] > 4'd7) ? 6'd1 : 6'd0);
				r.lon_or_mag_x = body_le32(OFS_LON, key);
				r.lat_or_mag_y = body_le32(OFS_LAT, key);
				r.altitude_mm = body_le32(OFS_ALT, key);
				r.north_velocity = body_le32(OFS_NVEL, key);
				r.east_velocity = body_le32(OFS_EVEL, key);
				r.climb_rate = (down == 32'h8000_0000) ? 32'h7FFF_FFFF : -down;
				r.dop_triple = {body_le16(OFS_VDOP, key), body_le16(OFS_NDOP, key),
					body_le16(OFS_EDOP, key)};
				r.satellites = body_mem[OFS_SATS];
				r.fix_class = (ft == FIX_TYPE_2D) ? FIX_2D :
					(ft == FIX_TYPE_3D) ? FIX_3D : FIX_NONE;
				if (r.fix_class != FIX_NONE && (ff & FLAG_DIFF) != 8'h00)
					r.fix_class = FIX_DIFF;
			end else begin
				key = compass_key(body_mem[OFS_MAGKEY]);
				mx = body_le16(OFS_MAG_X, key);
				my = body_le16(OFS_MAG_Y, key);
				if (mx > x_hi) x_hi = mx;
				if (mx < x_lo) x_lo = mx;
				if (my > y_hi) y_hi = my;
				if (my < y_lo) y_lo = my;
				// Integer division truncates toward zero, as the centring wants.
				r.frame_kind = KIND_COMPASS;
				r.lon_or_mag_x = int'(mx) - (int'(x_hi) + int'(x_lo)) / 2;
				r.lat_or_mag_y = int'(my) - (int'(y_hi) + int'(y_lo)) / 2;
			end
			decoded_frames.push_back(r);
		end
	endtask

	// Sends one byte in bursts with random gaps; the decoder model sees it on the beat.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) :
				$urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) @(negedge clk) rx_ch.valid <= 1'b0;
		end
		@(negedge clk);
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		decode_byte(b);
		burst_left--;
	endtask

	// Wraps body_buf into a frame with header and checksums. One byte may be
	// flipped, and the frame may be cut after keep bytes.
	task automatic send_frame(input logic [7:0] fid, input int flip_at = -1,
			input logic [7:0] flip_mask = 8'h00, input int keep = FRAME_MAX);
		logic [7:0] fr [FRAME_MAX];
		logic [7:0] len;
		logic [7:0] ca;
		logic [7:0] cb;
		int n;
		int i;
		len = (fid == ID_COMPASS) ? LEN_COMPASS : LEN_GPS;
		fr[0] = SYNC_1;
		fr[1] = SYNC_2;
		fr[POS_ID] = fid;
		fr[POS_LEN] = len;
		ca = fid;
		cb = ca;
		ca = ca + len;
		cb = cb + ca;
		for (i = 0; i < int'(len); i++) begin
			fr[HDR_BYTES + i] = body_buf[i];
			ca = ca + body_buf[i];
			cb = cb + ca;
		end
		n = HDR_BYTES + int'(len) + 2;
		fr[n - 2] = ca;
		fr[n - 1] = cb;
		if (flip_at >= 0 && flip_at < n)
			fr[flip_at] = fr[flip_at] ^ flip_mask;
		if (keep < n)
			n = keep;
		for (i = 0; i < n; i++)
			send_byte(fr[i]);
		frame_bytes += n;
	endtask

	task automatic fill_body_random();
		int i;
		for (i = 0; i < BODY_MAX; i++)
			body_buf[i] = $urandom_range(0, 255);
	endtask

	task automatic put_field(input int ofs, input int nbytes, input logic [31:0] val,
			input logic [7:0] key);
		int k;
		for (k = 0; k < nbytes; k++)
			body_buf[ofs + k] = val[8 * k +: 8] ^ key;
	endtask

	// GPS payload with the given raw field values under a random mask byte.
	task automatic load_gps_body(input logic [31:0] tword, lon, lat, alt, vn, ve, vd,
			input logic [47:0] dops, input logic [7:0] sats, ftype, fflag);
		logic [7:0] key;
		fill_body_random();
		key = body_buf[OFS_MASK];
		put_field(OFS_TIME, 4, tword, key);
		put_field(OFS_LON, 4, lon, key);
		put_field(OFS_LAT, 4, lat, key);
		put_field(OFS_ALT, 4, alt, key);
		put_field(OFS_NVEL, 4, vn, key);
		put_field(OFS_EVEL, 4, ve, key);
		put_field(OFS_DVEL, 4, vd, key);
		put_field(OFS_VDOP, 2, {16'h0, dops[47:32]}, key);
		put_field(OFS_NDOP, 2, {16'h0, dops[31:16]}, key);
		put_field(OFS_EDOP, 2, {16'h0, dops[15:0]}, key);
		body_buf[OFS_SATS] = sats;
		put_field(OFS_FTYPE, 1, {24'h0, ftype}, key);
		put_field(OFS_FFLAG, 1, {24'h0, fflag}, key);
	endtask

	// Compass payload carrying x and y under the mask that the key byte gives.
	task automatic load_compass_body(input logic signed [15:0] mx, my,
			input logic [7:0] seed);
		logic [7:0] key;
		fill_body_random();
		body_buf[OFS_MAGKEY] = seed;
		key = compass_key(seed);
		put_field(OFS_MAG_X, 2, {16'h0, mx}, key);
		put_field(OFS_MAG_Y, 2, {16'h0, my}, key);
	endtask

	// Field extremes, day rollover and climb-rate saturation.
	task automatic test_gps_fields();
		load_gps_body('0, '0, '0, '0, '0, '0, '0, '0, 8'h00, 8'h00, 8'h00);
		send_frame(ID_GPS);
		load_gps_body(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 48'hFFFF_8000_7FFF, 8'hFF,
			FIX_TYPE_3D, FLAG_DIFF);
		send_frame(ID_GPS);
		load_gps_body(32'h0000_7000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_8000, 8'h00,
			FIX_TYPE_2D, 8'h00);
		send_frame(ID_GPS);
		load_gps_body({7'd127, 4'd12, 5'd31, 4'd8, 6'd59, 6'd59}, $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), 32'h0000_0001, 48'h0001_0002_0003,
			8'h0C, FIX_TYPE_2D, 8'hFF);
		send_frame(ID_GPS);
		load_gps_body($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), 32'hFFFF_FFFF, {$urandom(), $urandom()}, 8'h07, FIX_TYPE_3D,
			8'h00);
		send_frame(ID_GPS);
	endtask

	// Fix type and flag combinations, differential only on a real fix.
	task automatic test_fix_classes();
		logic [7:0] ftypes [7];
		logic [7:0] fflags [7];
		int i;
		ftypes = '{FIX_TYPE_2D, FIX_TYPE_2D, FIX_TYPE_3D, FIX_TYPE_3D, 8'h00, 8'h01, 8'hFF};
		fflags = '{8'h00, FLAG_DIFF, 8'hFD, 8'hFF, FLAG_DIFF, 8'hFF, FLAG_DIFF};
		for (i = 0; i < 7; i++) begin
			load_gps_body($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), {$urandom(), $urandom()}, $urandom_range(0, 255),
				ftypes[i], fflags[i]);
			send_frame(ID_GPS);
		end
	endtask

	// Min/max store growth, odd sums truncated toward zero, 16-bit extremes.
	task automatic test_compass_centering();
		load_compass_body(16'sd0, 16'sd0, 8'h00);
		send_frame(ID_COMPASS);
		load_compass_body(16'sd100, -16'sd100, 8'h01);
		send_frame(ID_COMPASS);
		load_compass_body(-16'sd7, -16'sd101, 8'hFF);
		send_frame(ID_COMPASS);
		load_compass_body(16'sh7FFF, 16'sh8000, 8'hA5);
		send_frame(ID_COMPASS);
		load_compass_body(16'sh8000, 16'sh7FFF, 8'h5A);
		send_frame(ID_COMPASS);
		load_compass_body($urandom(), $urandom(), $urandom_range(0, 255));
		send_frame(ID_COMPASS);
	endtask

	// Broken headers, id/length pairs and checksums send the decoder back to hunting.
	task automatic test_broken_frames();
		// A second 0x55 where 0xAA belongs is not taken as a new header start.
		send_byte(SYNC_1);
		load_compass_body(16'sd50, -16'sd50, 8'h3C);
		send_frame(ID_COMPASS);
		send_frame(ID_COMPASS, POS_SYNC_2, 8'h01);
		send_frame(ID_COMPASS);
		// Length that belongs to the other id, and an id that is not known.
		send_frame(ID_GPS, POS_LEN, LEN_GPS ^ LEN_COMPASS);
		send_frame(ID_COMPASS, POS_LEN, LEN_GPS ^ LEN_COMPASS);
		send_frame(ID_COMPASS, POS_ID, 8'h40);
		// Each checksum byte wrong on its own.
		send_frame(ID_COMPASS, HDR_BYTES + int'(LEN_COMPASS), 8'h80);
		send_frame(ID_COMPASS, HDR_BYTES + int'(LEN_COMPASS) + 1, 8'h01);
		send_frame(ID_COMPASS);
		// A GPS frame cut short takes the next frame in as payload.
		send_frame(ID_GPS, -1, 8'h00, 20);
		send_frame(ID_COMPASS);
	endtask

	// Mostly well-formed frames with random content, plus damaged frames and noise.
	task automatic test_random_traffic();
		int start_results;
		int pick;
		int n;
		int i;
		logic [7:0] fid;
		logic [7:0] ft;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		frame_bytes = 0;
		start_results = results_seen;
		while (frame_bytes < RANDOM_BYTES || results_seen - start_results < RANDOM_RESULTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 88) begin
				fid = ($urandom_range(0, 99) < 70) ? ID_COMPASS : ID_GPS;
				if (fid == ID_COMPASS) begin
					// Small readings keep the store close; full-range ones stretch it.
					if ($urandom_range(0, 1)) begin
						mx = int'($urandom_range(0, 400)) - 200;
						my = int'($urandom_range(0, 400)) - 200;
					end else begin
						mx = $urandom();
						my = $urandom();
					end
					load_compass_body(mx, my, $urandom_range(0, 255));
				end else begin
					case ($urandom_range(0, 2))
						0: ft = FIX_TYPE_2D;
						1: ft = FIX_TYPE_3D;
						default: ft = $urandom_range(0, 255);
					endcase
					load_gps_body($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
						$urandom(), ($urandom_range(0, 7) == 0) ? 32'h8000_0000 : $urandom(),
						{$urandom(), $urandom()}, $urandom_range(0, 255), ft,
						$urandom_range(0, 255));
				end
				n = HDR_BYTES + int'((fid == ID_COMPASS) ? LEN_COMPASS : LEN_GPS) + 2;
				if (pick < 75)
					send_frame(fid);
				else if ($urandom_range(0, 1))
					send_frame(fid, $urandom_range(0, n - 1), $urandom_range(1, 255));
				else
					send_frame(fid, -1, 8'h00, $urandom_range(1, n - 1));
			end else begin
				// Line noise, with header bytes turning up often.
				n = $urandom_range(1, 12);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 5))
						0: send_byte(SYNC_1);
						1: send_byte(SYNC_2);
						default: send_byte($urandom_range(0, 255));
					endcase
				end
			end
		end
	endtask

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want)
			log_fault($sformatf("result %0d, %s: expected %h, got %h",
				results_seen, name, want, got));
	endtask

	// Each result beat is compared with the oldest decoded frame.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (decoded_frames.size() == 0) begin
				log_fault($sformatf("result %0d arrived with no frame decoded", results_seen));
			end else begin
				head_frame = decoded_frames.pop_front();
				check_field("frame_kind", head_frame.frame_kind, res_ch.frame_kind);
				check_field("time_word", head_frame.time_word, res_ch.time_word);
				check_field("corrected_day", head_frame.corrected_day, res_ch.corrected_day);
				check_field("lon_or_mag_x", head_frame.lon_or_mag_x, res_ch.lon_or_mag_x);
				check_field("lat_or_mag_y", head_frame.lat_or_mag_y, res_ch.lat_or_mag_y);
				check_field("altitude_mm", head_frame.altitude_mm, res_ch.altitude_mm);
				check_field("north_velocity", head_frame.north_velocity,
					res_ch.north_velocity);
				check_field("east_velocity", head_frame.east_velocity, res_ch.east_velocity);
				check_field("climb_rate", head_frame.climb_rate, res_ch.climb_rate);
				check_field("dop_triple", head_frame.dop_triple, res_ch.dop_triple);
				check_field("satellites", head_frame.satellites, res_ch.satellites);
				check_field("fix_class", head_frame.fix_class, res_ch.fix_class);
			end
			results_seen++;
		end
	end

	// Result side: stretches of steady, random and held-off ready.
	initial begin
		int span;
		int ready_pct;
		int pick;
		res_ch.ready = 1'b1;
		forever begin
			pick = $urandom_range(0, 99);
			span = $urandom_range(4, 60);
			ready_pct = (pick < 30) ? 100 : (pick < 70) ? 75 : (pick < 85) ? 25 : 0;
			if (ready_pct == 0)
				span = $urandom_range(1, 24);
			repeat (span) @(negedge clk) res_ch.ready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	// Ends the run when no beat moves on either side for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
					(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int i;
		for (i = 0; i < 64; i++)
			body_mem[i] = 8'h00;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_gps_fields();
		test_fix_classes();
		test_compass_centering();
		test_broken_frames();
		test_random_traffic();

		@(negedge clk) rx_ch.valid <= 1'b0;
		while (decoded_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/gcsfd_pkg.sv
rtl/gcsfd_byte_if.sv
rtl/gcsfd_result_if.sv
rtl/gps_compass_serial_frame_decoder_unit.sv
tb/testbench.sv
